[hdl/chunked_free_list_allocator_top_assert.svh]
// Assertion macros for the chunked free-list allocator.
// Included by the top level; needs clk_i and rst_ni in the including scope.
`ifndef CHUNKED_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH
`define CHUNKED_FREE_LIST_ALLOCATOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CFLA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CFLA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CFLA_ASSERT(lbl, prop, msg)
`define CFLA_NEVER(lbl, cond, msg)
`endif

`endif

[hdl/cfla_pkg.sv]
// Package of the chunked free-list allocator: types, codes and constants.
// Used by every module of the block but cfla_ram; depends on nothing.
package cfla_pkg;

  localparam int POOL_BLOCKS_DEF  = 64;
  localparam int CHUNK_BLOCKS_DEF = 5;

  localparam int IDX_W = 6;
  localparam int BB_W  = 9;
  localparam int OFS_W = 14;
  localparam int CNT_W = 7;
  localparam int PROD_W = IDX_W + BB_W;

  localparam logic [BB_W-1:0]  BLOCK_BYTES_RST = BB_W'(8);
  localparam logic [CNT_W-1:0] FREE_MAX        = CNT_W'(127);

  localparam logic ST_OK        = 1'b0;
  localparam logic ST_EXHAUSTED = 1'b1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_ALLOC,
    KIND_FREE,
    KIND_FREE_OUT
  } kind_e;

  typedef enum logic {
    BK_READY,
    BK_WAIT
  } back_state_e;

  typedef struct packed {
    logic             opcode;
    logic [IDX_W-1:0] block_index;
  } cfla_req_t;

  typedef struct packed {
    logic             status;
    logic [IDX_W-1:0] block_index_res;
    logic [OFS_W-1:0] byte_offset;
    logic [CNT_W-1:0] free_count;
  } cfla_rsp_t;

  typedef struct packed {
    kind_e            kind;
    logic [IDX_W-1:0] index;
  } cfla_cmd_t;

endpackage

[hdl/cfla_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; depends on nothing.
module cfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/cfla_queue.sv]
// Two-entry command queue between the front and back ends of the allocator.
// Depends on cfla_pkg.
module cfla_queue import cfla_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cfla_cmd_t din_i,
  input  logic      pop_i,
  output cfla_cmd_t dout_o,
  output logic      empty_o,
  output logic      full_o
);

  cfla_cmd_t  entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = ~wr_ptr_q;
    end
    if (pop_i) begin
      rd_ptr_d = ~rd_ptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= din_i;
    end
  end

  assign dout_o  = entry_q[rd_ptr_q];
  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);

endmodule

[hdl/cfla_front.sv]
// Front end of the allocator: takes request items and classifies them.
// Depends on cfla_pkg; feeds cfla_queue.
module cfla_front import cfla_pkg::*; #(
  parameter int POOL_BLOCKS = POOL_BLOCKS_DEF
) (
  input  logic      start_i,
  input  cfla_req_t req_i,
  input  logic      q_full_i,
  output logic      busy_o,
  output logic      push_o,
  output cfla_cmd_t cmd_o
);

  logic in_pool;

  assign in_pool = (32'(req_i.block_index) < POOL_BLOCKS);
  assign busy_o  = q_full_i;
  assign push_o  = start_i && !q_full_i;

  always_comb begin
    cmd_o.index = req_i.block_index;
    if (req_i.opcode == OP_ALLOC) begin
      cmd_o.kind = KIND_ALLOC;
    end else if (in_pool) begin
      cmd_o.kind = KIND_FREE;
    end else begin
      cmd_o.kind = KIND_FREE_OUT;
    end
  end

endmodule

[hdl/cfla_back.sv]
// Back end of the allocator: free list, carved run, pool bump and results.
// Depends on cfla_pkg and cfla_ram; drains cfla_queue.
module cfla_back import cfla_pkg::*; #(
  parameter int POOL_BLOCKS  = POOL_BLOCKS_DEF,
  parameter int CHUNK_BLOCKS = CHUNK_BLOCKS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_empty_i,
  input  cfla_cmd_t       cmd_i,
  input  logic [BB_W-1:0] block_bytes_i,
  output logic            pop_o,
  output logic            done_o,
  output cfla_rsp_t       rsp_o
);

  localparam int PTR_W  = $clog2(POOL_BLOCKS + 1);
  localparam int ADDR_W = $clog2(POOL_BLOCKS);
  localparam int RUN_W  = $clog2(CHUNK_BLOCKS + 1);

  back_state_e state_q, state_d;

  logic [PTR_W-1:0]  head_q, head_d;
  logic [ADDR_W-1:0] run_next_q, run_next_d;
  logic [RUN_W-1:0]  run_left_q, run_left_d;
  logic [PTR_W-1:0]  bump_q, bump_d;
  logic [CNT_W-1:0]  free_q, free_d;
  logic              done_q;
  cfla_rsp_t         rsp_q, rsp_d;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [PTR_W-1:0]  ram_rdata;

  logic              list_empty;
  logic [PTR_W-1:0]  avail;
  logic [RUN_W-1:0]  carve_n;
  logic [7:0]        carve_sum;
  logic [IDX_W-1:0]  res_idx;
  logic              res_status;
  logic [PROD_W-1:0] prod;

  cfla_ram #(
    .WIDTH (PTR_W),
    .DEPTH (POOL_BLOCKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (head_q),
    .raddr_i (head_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_READY: begin
        if (!q_empty_i) begin
          state_d = BK_WAIT;
        end
      end
      BK_WAIT: state_d = BK_READY;
      default: state_d = BK_READY;
    endcase
  end

  always_comb begin
    pop_o = (state_q == BK_READY) && !q_empty_i;
  end

  assign list_empty = (head_q == PTR_W'(POOL_BLOCKS));
  assign avail      = PTR_W'(POOL_BLOCKS) - bump_q;
  assign carve_n    = (32'(avail) > CHUNK_BLOCKS) ? RUN_W'(CHUNK_BLOCKS) : RUN_W'(avail);
  assign carve_sum  = {1'b0, free_q} + (8'(carve_n) - 8'd1);
  assign ram_waddr  = ADDR_W'(cmd_i.index);

  always_comb begin
    head_d     = head_q;
    run_next_d = run_next_q;
    run_left_d = run_left_q;
    bump_d     = bump_q;
    free_d     = free_q;
    ram_we     = 1'b0;
    res_idx    = '0;
    res_status = ST_OK;
    if (pop_o) begin
      case (cmd_i.kind)
        KIND_FREE: begin
          ram_we  = 1'b1;
          head_d  = PTR_W'(cmd_i.index);
          res_idx = cmd_i.index;
          if (free_q != FREE_MAX) begin
            free_d = free_q + 1'b1;
          end
        end
        KIND_FREE_OUT: res_idx = cmd_i.index;
        KIND_ALLOC: begin
          if (!list_empty) begin
            res_idx = IDX_W'(head_q);
            head_d  = ram_rdata;
            if (free_q != '0) begin
              free_d = free_q - 1'b1;
            end
          end else if (run_left_q != '0) begin
            res_idx    = IDX_W'(run_next_q);
            run_next_d = run_next_q + 1'b1;
            run_left_d = run_left_q - 1'b1;
            if (free_q != '0) begin
              free_d = free_q - 1'b1;
            end
          end else if (bump_q < PTR_W'(POOL_BLOCKS)) begin
            res_idx    = IDX_W'(bump_q);
            run_next_d = ADDR_W'(bump_q + 1'b1);
            run_left_d = carve_n - 1'b1;
            bump_d     = bump_q + PTR_W'(carve_n);
            if (carve_sum > 8'(FREE_MAX)) begin
              free_d = FREE_MAX;
            end else begin
              free_d = carve_sum[CNT_W-1:0];
            end
          end else begin
            res_status = ST_EXHAUSTED;
          end
        end
        default: ;
      endcase
    end
  end

  assign prod = PROD_W'(res_idx) * PROD_W'(block_bytes_i);

  always_comb begin
    rsp_d.status          = res_status;
    rsp_d.block_index_res = res_idx;
    rsp_d.byte_offset     = prod[OFS_W-1:0];
    rsp_d.free_count      = free_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_READY;
      head_q     <= PTR_W'(POOL_BLOCKS);
      run_next_q <= '0;
      run_left_q <= '0;
      bump_q     <= '0;
      free_q     <= '0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      run_next_q <= run_next_d;
      run_left_q <= run_left_d;
      bump_q     <= bump_d;
      free_q     <= free_d;
      done_q     <= pop_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

[hdl/chunked_free_list_allocator_top.sv]
// Top level of the chunked free-list allocator.
// Depends on cfla_pkg, cfla_front, cfla_queue, cfla_back and the assertion header.

// A request item is taken at a clock edge where start is high and busy is low.
// Each item gives exactly one result, shown for one cycle with done_o high;
// the receiver must take it then, as results cannot be held back. The back end
// takes an item only in its ready state and then passes a wait state, in which
// the registered read of the next-link memory follows any change of the list head;
// the result appears the cycle after the back end takes the item. Up to two items
// wait in the queue between the front and back ends; busy is high when it is full.
// No clearing pass runs after reset, and block_bytes resets to 8.
`include "chunked_free_list_allocator_top_assert.svh"

module chunked_free_list_allocator_top import cfla_pkg::*; #(
  parameter int POOL_BLOCKS  = POOL_BLOCKS_DEF,
  parameter int CHUNK_BLOCKS = CHUNK_BLOCKS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  cfla_req_t       req_i,
  output logic            done_o,
  output cfla_rsp_t       rsp_o,
  input  logic            cfg_we_i,
  input  logic [BB_W-1:0] cfg_wdata_i
);

  logic [BB_W-1:0] block_bytes_q;
  logic            push;
  logic            pop;
  logic            q_empty;
  logic            q_full;
  cfla_cmd_t       cmd_in;
  cfla_cmd_t       cmd_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bytes_q <= BLOCK_BYTES_RST;
    end else if (cfg_we_i) begin
      block_bytes_q <= cfg_wdata_i;
    end
  end

  cfla_front #(
    .POOL_BLOCKS (POOL_BLOCKS)
  ) u_front (
    .start_i  (start),
    .req_i    (req_i),
    .q_full_i (q_full),
    .busy_o   (busy),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  cfla_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (cmd_in),
    .pop_i   (pop),
    .dout_o  (cmd_out),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  cfla_back #(
    .POOL_BLOCKS  (POOL_BLOCKS),
    .CHUNK_BLOCKS (CHUNK_BLOCKS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .cmd_i         (cmd_out),
    .block_bytes_i (block_bytes_q),
    .pop_o         (pop),
    .done_o        (done_o),
    .rsp_o         (rsp_o)
  );

  `CFLA_NEVER(a_no_overflow, push && q_full, "Item pushed into a full queue.")
  `CFLA_NEVER(a_no_underflow, pop && q_empty, "Item popped from an empty queue.")
  `CFLA_ASSERT(a_done_single, done_o |=> !done_o, "Results on two cycles in a row.")
  `CFLA_ASSERT(a_done_after_pop, done_o |-> $past(pop), "Result without a taken item.")

endmodule
